### design/rgbpk_pkg.sv
// Shared types, constants and helpers for the RGB to six-color palette packer.
// No dependencies; imported by every module of the block.
package rgbpk_pkg;

    // Widths of the stream fields
    localparam int ChanW    = 8;
    localparam int IndexW   = 19;
    localparam int ByteIdxW = 18;
    localparam int CodeW    = 4;
    localparam int DistW    = 18;   // 3 * 255^2 fits in 18 bits
    localparam int InDataW  = 48;
    localparam int OutDataW = 24;

    // Frame size; an index of this value or more wraps once
    localparam logic [IndexW:0] MaxPixels = 20'd524288;

    // Configuration port
    localparam int AddrW   = 5;
    localparam int PDataW  = 32;
    localparam logic [ChanW-1:0] TolReset = 8'd6;

    typedef enum logic [2:0] {
        RegTolerance  = 3'd0,
        RegCodeBlack  = 3'd1,
        RegCodeWhite  = 3'd2,
        RegCodeYellow = 3'd3,
        RegCodeRed    = 3'd4,
        RegCodeBlue   = 3'd5,
        RegCodeGreen  = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ColBlack  = 3'd0,
        ColWhite  = 3'd1,
        ColRed    = 3'd2,
        ColGreen  = 3'd3,
        ColBlue   = 3'd4,
        ColYellow = 3'd5
    } color_t;

    // Panel codes, one per color
    typedef struct packed {
        logic [CodeW-1:0] black;
        logic [CodeW-1:0] white;
        logic [CodeW-1:0] yellow;
        logic [CodeW-1:0] red;
        logic [CodeW-1:0] blue;
        logic [CodeW-1:0] green;
    } codes_t;

    // Word traveling down the row of cells
    typedef struct packed {
        logic [ChanW-1:0]    red;
        logic [ChanW-1:0]    green;
        logic [ChanW-1:0]    blue;
        logic [ByteIdxW-1:0] byte_index;
        logic                upper_nibble;
        logic                locked;      // primary near-match already decided
        logic [DistW-1:0]    best_dist;
        color_t              best_color;
    } pix_t;

    // Pure primaries in check order, {r,g,b}
    localparam int NumPrim = 6;
    localparam logic [23:0] PrimRgb [NumPrim] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00
    };

    // Palette in search order, {r,g,b}
    localparam int NumPal = 12;
    localparam logic [23:0] PalRgb [NumPal] = '{
        24'h000000, 24'h191E21, 24'hFFFFFF, 24'hE8E8E8,
        24'hFF0000, 24'hB21318, 24'h0000FF, 24'h2157BA,
        24'h00FF00, 24'h125F20, 24'hFFFF00, 24'hEFDE44
    };
    localparam color_t PalColor [NumPal] = '{
        ColBlack, ColBlack, ColWhite, ColWhite, ColRed, ColRed,
        ColBlue, ColBlue, ColGreen, ColGreen, ColYellow, ColYellow
    };

    function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [2*ChanW-1:0] sq_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
        logic [ChanW-1:0] d;
        d = abs_diff(a, b);
        return {{ChanW{1'b0}}, d} * {{ChanW{1'b0}}, d};
    endfunction

endpackage

### design/rgbpk_front.sv
// Entry stage: primary near-match checks and framebuffer position.
// Depends on rgbpk_pkg.
module rgbpk_front
    import rgbpk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ChanW-1:0]    red,
    input  logic [ChanW-1:0]    green,
    input  logic [ChanW-1:0]    blue,
    input  logic [IndexW-1:0]   pixel_index,
    input  logic [ChanW-1:0]    tolerance,
    output logic                out_valid,
    input  logic                out_ready,
    output pix_t                out_word
);

    logic           valid_reg;
    pix_t           data_reg;
    pix_t           data_next;
    logic           match;
    color_t         match_color;
    logic [IndexW:0] idx_ext;
    logic [IndexW:0] idx_wrap;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = data_reg;

    // Single wrap: a 19-bit index stays below twice the frame size
    assign idx_ext  = {1'b0, pixel_index};
    assign idx_wrap = (idx_ext >= MaxPixels) ? idx_ext - MaxPixels : idx_ext;

    // First primary in check order within tolerance on all channels
    always_comb
    begin
        match       = 1'b0;
        match_color = ColWhite;
        for (int i = NumPrim - 1; i >= 0; i--)
        begin
            if (abs_diff(red,   PrimRgb[i][23:16]) <= tolerance &&
                abs_diff(green, PrimRgb[i][15:8])  <= tolerance &&
                abs_diff(blue,  PrimRgb[i][7:0])   <= tolerance)
            begin
                match       = 1'b1;
                match_color = color_t'(3'(i));
            end
        end
    end

    always_comb
    begin
        data_next.red          = red;
        data_next.green        = green;
        data_next.blue         = blue;
        data_next.byte_index   = idx_wrap[ByteIdxW:1];
        data_next.upper_nibble = ~idx_wrap[0];
        data_next.locked       = match;
        data_next.best_dist    = '1;
        data_next.best_color   = match_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

### design/rgbpk_cell.sv
// One palette cell: squared distance to its entry, keeps the running best.
// Depends on rgbpk_pkg.
module rgbpk_cell
    import rgbpk_pkg::*;
#(
    parameter int ENTRY = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  pix_t in_word,
    output logic out_valid,
    input  logic out_ready,
    output pix_t out_word
);

    localparam logic [ChanW-1:0] EntR = PalRgb[ENTRY][23:16];
    localparam logic [ChanW-1:0] EntG = PalRgb[ENTRY][15:8];
    localparam logic [ChanW-1:0] EntB = PalRgb[ENTRY][7:0];
    localparam color_t EntColor = PalColor[ENTRY];

    logic             valid_reg;
    pix_t             data_reg;
    pix_t             data_next;
    logic [DistW-1:0] cand_dist;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = data_reg;

    assign cand_dist = {2'b00, sq_diff(in_word.red,   EntR)}
                     + {2'b00, sq_diff(in_word.green, EntG)}
                     + {2'b00, sq_diff(in_word.blue,  EntB)};

    // Strictly closer wins, so the earlier entry keeps a tie
    always_comb
    begin
        data_next = in_word;
        if (!in_word.locked && cand_dist < in_word.best_dist)
        begin
            data_next.best_dist  = cand_dist;
            data_next.best_color = EntColor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

### design/rgbpk_out.sv
// Output stage: maps the chosen color to its panel code and holds the word.
// Depends on rgbpk_pkg.
module rgbpk_out
    import rgbpk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pix_t                in_word,
    input  codes_t              codes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OutDataW-1:0] out_data
);

    logic                valid_reg;
    logic [OutDataW-1:0] data_reg;
    logic [OutDataW-1:0] data_next;
    logic [CodeW-1:0]    code;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Color to panel code
    always_comb
    begin
        unique case (in_word.best_color)
            ColBlack:  code = codes.black;
            ColWhite:  code = codes.white;
            ColRed:    code = codes.red;
            ColGreen:  code = codes.green;
            ColBlue:   code = codes.blue;
            ColYellow: code = codes.yellow;
            default:   code = codes.yellow;
        endcase
    end

    assign data_next = {1'b0, in_word.upper_nibble, in_word.byte_index, code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

### design/rgb_to_six_color_palette_packer_core.sv
// Top level of the RGB to six-color palette packer: config registers and the cell row.
// Depends on rgbpk_pkg, rgbpk_front, rgbpk_cell and rgbpk_out.
//
// Takes one pixel word per clock while the output is not stalled and returns
// one packed word per pixel, in order. A pixel that lies within the tolerance
// of a pure primary (checked as black, white, red, green, blue, yellow) takes
// that color; otherwise it takes the nearest of twelve palette entries by
// squared distance, the earlier entry winning a tie. Throughput is one pixel
// per cycle when the output does not stall. A pixel passes one entry stage for
// the primary checks, one stage per palette entry in the row of twelve cells,
// and the output register. Every stage has its own valid bit, so empty slots in
// the row close up while the output is stalled. Registers (byte address):
// 0x00 tolerance, 0x04 black, 0x08 white, 0x0C yellow, 0x10 red, 0x14 blue,
// 0x18 green code; write them only while no pixel is in flight.
module rgb_to_six_color_palette_packer_core
    import rgbpk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [PDataW-1:0]   pwdata,
    output logic [PDataW-1:0]   prdata,
    output logic                pready,
    // Pixel stream in
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // red[7:0] green[15:8] blue[23:16]
                                                // pixel_index[42:24], zero pad
    // Packed stream out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata    // color_code[3:0] byte_index[21:4]
                                                // upper_nibble[22], zero pad
);

    localparam int NumStages = NumPal + 1;

    logic [ChanW-1:0] tolerance_reg;
    codes_t           codes_reg;
    reg_idx_t         wr_idx;
    logic             wr_en;

    logic stage_valid [NumStages];
    logic stage_ready [NumStages];
    pix_t stage_word  [NumStages];
    logic out_ready_in;

    // Config registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[AddrW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg    <= TolReset;
            codes_reg.black  <= 4'd0;
            codes_reg.white  <= 4'd1;
            codes_reg.yellow <= 4'd2;
            codes_reg.red    <= 4'd3;
            codes_reg.blue   <= 4'd5;
            codes_reg.green  <= 4'd6;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                RegTolerance:  tolerance_reg    <= pwdata[ChanW-1:0];
                RegCodeBlack:  codes_reg.black  <= pwdata[CodeW-1:0];
                RegCodeWhite:  codes_reg.white  <= pwdata[CodeW-1:0];
                RegCodeYellow: codes_reg.yellow <= pwdata[CodeW-1:0];
                RegCodeRed:    codes_reg.red    <= pwdata[CodeW-1:0];
                RegCodeBlue:   codes_reg.blue   <= pwdata[CodeW-1:0];
                RegCodeGreen:  codes_reg.green  <= pwdata[CodeW-1:0];
                default:       ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (wr_idx)
            RegTolerance:  prdata = {{(PDataW-ChanW){1'b0}}, tolerance_reg};
            RegCodeBlack:  prdata = {{(PDataW-CodeW){1'b0}}, codes_reg.black};
            RegCodeWhite:  prdata = {{(PDataW-CodeW){1'b0}}, codes_reg.white};
            RegCodeYellow: prdata = {{(PDataW-CodeW){1'b0}}, codes_reg.yellow};
            RegCodeRed:    prdata = {{(PDataW-CodeW){1'b0}}, codes_reg.red};
            RegCodeBlue:   prdata = {{(PDataW-CodeW){1'b0}}, codes_reg.blue};
            RegCodeGreen:  prdata = {{(PDataW-CodeW){1'b0}}, codes_reg.green};
            default:       prdata = '0;
        endcase
    end

    // Entry stage
    rgbpk_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .red         (s_axis_tdata[7:0]),
        .green       (s_axis_tdata[15:8]),
        .blue        (s_axis_tdata[23:16]),
        .pixel_index (s_axis_tdata[42:24]),
        .tolerance   (tolerance_reg),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_word    (stage_word[0])
    );

    // Row of palette cells, one per entry in search order
    for (genvar i = 0; i < NumPal; i++)
    begin : g_cell
        rgbpk_cell #(
            .ENTRY (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready ((i == NumPal - 1) ? out_ready_in : stage_ready[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    // Code lookup and output register
    rgbpk_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NumStages-1]),
        .in_ready  (out_ready_in),
        .in_word   (stage_word[NumStages-1]),
        .codes     (codes_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // Last stage's ready comes from the output stage
    assign stage_ready[NumStages-1] = out_ready_in;

endmodule

### design/rgbpk_chk.sv
// Port-level checker for the palette packer, bound to the top level.
// Depends on rgbpk_pkg and rgb_to_six_color_palette_packer_core.
module rgbpk_chk
    import rgbpk_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [AddrW-1:0]    paddr,
    input logic [PDataW-1:0]   pwdata,
    input logic [PDataW-1:0]   prdata,
    input logic                pready,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [InDataW-1:0]  s_axis_tdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // An empty output means every stage can move, so input is taken
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output is empty");

    // Tolerance written then read back directly
    a_tol_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == 5'd0
        |=> !(psel && !pwrite && paddr == 5'd0) || prdata == {24'd0, $past(pwdata[7:0])})
        else $error("tolerance readback mismatch");

    // Pad bit of a result word is zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[OutDataW-1])
        else $error("output pad bit set");

endmodule

bind rgb_to_six_color_palette_packer_core rgbpk_chk u_rgbpk_chk (.*);
